// ===== src/dpf_pkg.sv =====
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared constants for the delimited packet framer: store geometry, field
// widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package dpf_pkg;

  localparam int PACKET_CAPACITY = 64;
  localparam int ADDR_W          = $clog2(PACKET_CAPACITY);
  localparam int CNT_W           = $clog2(PACKET_CAPACITY + 1);

  localparam int BYTE_W          = 8;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 8;

  // packets of this many bytes or fewer are dropped
  localparam logic [CNT_W-1:0] SHORT_LIMIT = CNT_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'd1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd170;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd85;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== src/delimited_packet_framer.sv =====
// ----------------------------------------------------------------------------
// delimited_packet_framer
// Collects start/end delimited packets into a byte store and replays each
// completed packet longer than SHORT_LIMIT bytes with tlast on its final byte.
// ----------------------------------------------------------------------------
// Collecting: one byte accepted per cycle; each byte of an open packet is written.
// Replay: the input stalls until the final byte is read from the store. The
// first byte is read into the output register once replay starts, then one byte
// per cycle while the sink is ready. The single store port forces the stall.
// Reset (rst_n low, synchronous): no packet open, markers 170/85, outputs idle.
// ----------------------------------------------------------------------------
module delimited_packet_framer (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [dpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  // output stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] packet_byte
  output logic                             out_tlast   // last_of_packet
);
  import dpf_pkg::*;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_REPLAY  = 1'b1;

  logic                 state_r, state_nxt;
  byte_t                start_marker_r, end_marker_r;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]     len_r, len_nxt;
  logic [CNT_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r;
  byte_t                rd_data_r;

  byte_t                store [PACKET_CAPACITY];

  logic                 in_fire, out_fire;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 rd_en;
  logic                 rd_last;
  logic [CNT_W-1:0]     n_new;
  byte_t                b;

  assign b        = in_tdata;
  assign in_tready = (state_r == ST_COLLECT);
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;

  // a store read is issued only when the output register frees up
  assign rd_en   = (state_r == ST_REPLAY) && (rd_ptr_r < len_r) &&
                   (!out_valid_r || out_tready);
  assign rd_last = (rd_ptr_r + CNT_W'(1)) == len_r;
  assign n_new   = fill_r + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_en         = 1'b0;
    wr_addr       = fill_r[ADDR_W-1:0];
    out_valid_nxt = out_valid_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_COLLECT: begin
        if (in_fire) begin
          if (b == start_marker_r) begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            fill_nxt = CNT_W'(1);
          end else if (fill_r != '0) begin
            wr_en = 1'b1;
            if (b == end_marker_r) begin
              fill_nxt = '0;
              if (n_new > SHORT_LIMIT) begin
                len_nxt    = n_new;
                rd_ptr_nxt = '0;
                state_nxt  = ST_REPLAY;
              end
            end else if (n_new == CNT_W'(PACKET_CAPACITY)) begin
              fill_nxt = '0;   // overlong, discard
            end else begin
              fill_nxt = n_new;
            end
          end
        end
      end
      ST_REPLAY: begin
        if (rd_en) begin
          out_valid_nxt = 1'b1;
          rd_ptr_nxt    = rd_ptr_r + CNT_W'(1);
          if (rd_last) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_COLLECT;
      fill_r         <= '0;
      len_r          <= '0;
      rd_ptr_r       <= '0;
      out_valid_r    <= 1'b0;
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_MARKER: start_marker_r <= cfg_data;
          REG_END_MARKER:   end_marker_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // packet store, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= b;
    end
    if (rd_en) begin
      rd_data_r  <= store[rd_ptr_r[ADDR_W-1:0]];
      out_last_r <= rd_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rd_data_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------- checks
  a_fill_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CNT_W'(PACKET_CAPACITY))
    else $error("fill count reached store capacity");

  a_replay_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLAY) |-> (fill_r == '0))
    else $error("packet open during replay");

  a_last_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && rd_last) |=> (state_r == ST_COLLECT) && out_valid_r && out_last_r)
    else $error("replay did not end on final byte");

  a_replay_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLAY) |-> (len_r > SHORT_LIMIT) && (rd_ptr_r < len_r))
    else $error("replay length or pointer out of range");

endmodule
